FILE: rtl/smms_pkg.sv
package smms_pkg;

	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_MAX_COLS = 16;

	localparam int SIZE_W = 5;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;

	// request kinds carried on tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// register select, taken from paddr[2]
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
	} smms_sizes_t;

endpackage

FILE: rtl/sorted_matrix_membership_search_top.sv
// Sorted matrix membership search.
// The matrix (signed 32-bit entries, row-major sorted) lives in an on-chip RAM
// of MAX_ROWS x MAX_COLS words. The size in use is set over the APB port:
// rows_in_use at byte address 0, cols_in_use at byte address 4.
// Input stream (s_axis): tuser selects load (0) or query (1). A load writes one
// entry and returns nothing; a query returns one transaction on m_axis with
// found in tdata bit 0.
// Each load writes its entry as it is taken; the input stays ready. A query
// walks the RAM one read per cycle: two reads for the range check, up to
// rows_in_use reads down the last column and up to cols_in_use reads across
// the chosen row, then hands the answer to the output register, after which
// the next transaction can be taken.
// The single RAM read port sets the pace of a query; s_axis_tready is low
// while a query is in flight.
// The answer waits in an output register while m_axis_tready is low, and the
// next transaction is taken meanwhile; a second query finishing behind it
// holds until the register drains.
// Reset clears the size registers and the control; the RAM is not cleared and
// entries must be loaded before a query reads them.
module sorted_matrix_membership_search_top import smms_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row_index[3:0], col_index[7:4], item_value[39:8]
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // found[0], zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	smms_sizes_t              sizes;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [AW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;
	logic                     found;

	smms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sizes   (sizes)
	);

	smms_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	smms_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sizes     (sizes),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_type   (s_axis_tuser),
		.in_row    (s_axis_tdata[3:0]),
		.in_col    (s_axis_tdata[7:4]),
		.in_value  (s_axis_tdata[39:8]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (found),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign m_axis_tdata = {7'd0, found};

endmodule

FILE: rtl/smms_mem.sv
module smms_mem import smms_pkg::*; #(
	parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
	parameter int AW    = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/smms_cfg.sv
module smms_cfg import smms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output smms_sizes_t       sizes
);

	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			cols_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[SIZE_W-1:0];
				REG_COLS: cols_q <= pwdata[SIZE_W-1:0];
				default:  rows_q <= rows_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = {{(32-SIZE_W){1'b0}}, rows_q};
			REG_COLS: prdata = {{(32-SIZE_W){1'b0}}, cols_q};
			default:  prdata = '0;
		endcase
	end

	assign sizes.rows = rows_q;
	assign sizes.cols = cols_q;

endmodule

FILE: rtl/smms_ctrl.sv
module smms_ctrl import smms_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int AW       = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smms_sizes_t              sizes,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_type,
	input  logic [IDX_W-1:0]         in_row,
	input  logic [IDX_W-1:0]         in_col,
	input  logic signed [DATA_W-1:0] in_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_found,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic signed [DATA_W-1:0] mem_wdata,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_raddr,
	input  logic signed [DATA_W-1:0] mem_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]               st_q, st_d;
	logic [SIZE_W-1:0]        r_q, r_d;
	logic [SIZE_W-1:0]        c_q, c_d;
	logic                     res_q, res_d;
	logic signed [DATA_W-1:0] target_q;
	logic                     out_valid_q;
	logic                     found_q;

	logic [SIZE_W-1:0]        rows_c;
	logic [SIZE_W-1:0]        cols_c;
	logic [SIZE_W-1:0]        rd_r;
	logic [SIZE_W-1:0]        rd_c;
	logic                     load_ok;
	logic                     in_fire;
	logic                     out_free;

	function automatic logic [AW-1:0] addr_of(input logic [SIZE_W-1:0] r,
			input logic [SIZE_W-1:0] c);
		return AW'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	// size registers above the array bounds are clamped
	assign rows_c = ({{(32-SIZE_W){1'b0}}, sizes.rows} > MAX_ROWS) ?
			SIZE_W'(MAX_ROWS) : sizes.rows;
	assign cols_c = ({{(32-SIZE_W){1'b0}}, sizes.cols} > MAX_COLS) ?
			SIZE_W'(MAX_COLS) : sizes.cols;

	assign load_ok  = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
	assign in_ready = (st_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign mem_waddr = addr_of({1'b0, in_row}, {1'b0, in_col});
	assign mem_wdata = in_value;
	assign mem_raddr = addr_of(rd_r, rd_c);

	always_comb begin
		st_d   = st_q;
		r_d    = r_q;
		c_d    = c_q;
		res_d  = res_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		rd_r   = r_q;
		rd_c   = c_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_type == REQ_LOAD) begin
						mem_we = load_ok;
					end else if (rows_c == '0 || cols_c == '0) begin
						res_d = 1'b0;
						st_d  = ST_FIN;
					end else begin
						mem_re = 1'b1;
						rd_r   = '0;
						rd_c   = '0;
						st_d   = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				if (target_q < mem_rdata) begin
					res_d = 1'b0;
					st_d  = ST_FIN;
				end else begin
					mem_re = 1'b1;
					rd_r   = rows_c - 1'b1;
					rd_c   = cols_c - 1'b1;
					st_d   = ST_LAST;
				end
			end
			ST_LAST: begin
				if (target_q > mem_rdata) begin
					res_d = 1'b0;
					st_d  = ST_FIN;
				end else begin
					mem_re = 1'b1;
					rd_r   = '0;
					rd_c   = cols_c - 1'b1;
					r_d    = '0;
					st_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				// mem_rdata holds the last entry of row r_q
				if (mem_rdata == target_q) begin
					res_d = 1'b1;
					st_d  = ST_FIN;
				end else if (mem_rdata > target_q) begin
					mem_re = 1'b1;
					rd_r   = r_q;
					rd_c   = cols_c - 1'b1;
					c_d    = cols_c - 1'b1;
					st_d   = ST_SCAN;
				end else if (r_q == rows_c - 1'b1) begin
					res_d = 1'b0;
					st_d  = ST_FIN;
				end else begin
					mem_re = 1'b1;
					rd_r   = r_q + 1'b1;
					rd_c   = cols_c - 1'b1;
					r_d    = r_q + 1'b1;
				end
			end
			ST_SCAN: begin
				if (mem_rdata == target_q) begin
					res_d = 1'b1;
					st_d  = ST_FIN;
				end else if (c_q == '0) begin
					res_d = 1'b0;
					st_d  = ST_FIN;
				end else begin
					mem_re = 1'b1;
					rd_r   = r_q;
					rd_c   = c_q - 1'b1;
					c_d    = c_q - 1'b1;
				end
			end
			ST_FIN: begin
				// hold the answer until the output register frees up
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		r_q   <= r_d;
		c_q   <= c_d;
		res_q <= res_d;
		if (in_fire) begin
			target_q <= in_value;
		end
		if (st_q == ST_FIN && out_free) begin
			found_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = found_q;

endmodule

FILE: rtl/smms_chk.sv
module smms_chk import smms_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("nonzero fill bits in result");

	// a load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result produced by a load");

	// a query keeps the input side busy in the cycle after it is taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_QUERY |=> !s_axis_tready)
		else $error("input accepted while a query is in flight");

endmodule

bind sorted_matrix_membership_search_top smms_chk u_smms_chk (.*);
